@@ rtl/mmc_pkg.sv @@
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and constants for the magnetometer min/max calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  localparam int NLANES    = 3;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int DIV_STEPS = 16;
  localparam int TS_W      = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_W-1:0] COHERENCY_RESET = 16'd2048;
  localparam logic [CFG_W-1:0] GAIN_RESET      = 16'd6554;
  localparam logic [CFG_W-1:0] ERR_LIMIT_RESET = 16'd100;

  typedef enum logic [1:0] {
    REG_COHERENCY = 2'd0,
    REG_GAIN      = 2'd1,
    REG_ERR_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FAIL = 2'd1,
    STAT_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic upd;
    logic clear;
    logic load;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic upd;
    logic sum;
    logic clear;
  } merge_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mmc_if.sv @@
// ----------------------------------------------------------------------------
// mmc_in_if / mmc_out_if
// Valid/ready channels for sensor ticks and calibration results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmc_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [31:0]                   timestamp;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic signed [SAMPLE_BITS-1:0] mag_z;
  logic                          last;

  modport source (output valid, timestamp, mag_x, mag_y, mag_z, last, input ready);
  modport sink   (input valid, timestamp, mag_x, mag_y, mag_z, last, output ready);
endinterface

interface mmc_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [15:0]                   error_count;
  logic signed [SAMPLE_BITS-1:0] bias_x;
  logic signed [SAMPLE_BITS-1:0] bias_y;
  logic signed [SAMPLE_BITS-1:0] bias_z;
  logic [15:0]                   gain_x;
  logic [15:0]                   gain_y;
  logic [15:0]                   gain_z;

  modport source (output valid, status, error_count, bias_x, bias_y, bias_z,
                  gain_x, gain_y, gain_z, input ready);
  modport sink   (input valid, status, error_count, bias_x, bias_y, bias_z,
                  gain_x, gain_y, gain_z, output ready);
endinterface

`default_nettype wire

@@ rtl/mmc_lane.sv @@
// ----------------------------------------------------------------------------
// mmc_lane
// One axis: min/max/last tracking and a restoring divider for the gain.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mmc_pkg::lane_ctrl_t             ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  input  wire logic [mmc_pkg::CFG_W-1:0]       coherency_limit,
  input  wire logic [mmc_pkg::CFG_W-1:0]       tracking_gain,
  input  wire logic [SAMPLE_BITS+1:0]          total,
  output logic                                 err,
  output logic                                 zero,
  output logic [SAMPLE_BITS-1:0]               range,
  output logic signed [SAMPLE_BITS-1:0]        bias,
  output logic [mmc_pkg::GAIN_W-1:0]           gain
);
  import mmc_pkg::*;

  localparam int B      = SAMPLE_BITS;
  localparam int B1     = B + 1;
  localparam int DW     = B + 2;
  localparam int TW     = B + 3;
  localparam int PW     = B + CFG_W;
  localparam int CW     = (B1 > CFG_W) ? B1 : CFG_W;
  localparam int SH     = DIV_STEPS - GAIN_FRAC;
  localparam int VL_INT = (79 * (1 << (B - 4))) / 10;
  localparam logic signed [B:0] VLIM     = B1'(VL_INT);
  localparam logic signed [B:0] NEG_VLIM = -VLIM;

  logic signed [B-1:0] min_r, max_r, last_r;
  logic                seen_r;

  logic signed [B:0]   s_ext, min_ext, max_ext, last_ext;
  logic signed [B:0]   jump, dmag, diff, bsum;
  logic [B:0]          jabs;
  logic [B-1:0]        step;
  logic [PW-1:0]       prod;
  logic                valid, jump_bad, above, below;

  logic [DW-1:0]        d_r, rem_r, d_calc, rem_nxt;
  logic [DIV_STEPS-1:0] nlo_r, q_r;
  logic                 ovf_r, ge;
  logic [TW-1:0]        trial;

  assign s_ext    = B1'(sample);
  assign min_ext  = B1'(min_r);
  assign max_ext  = B1'(max_r);
  assign last_ext = B1'(last_r);

  assign valid    = (s_ext >= NEG_VLIM) && (s_ext <= VLIM);
  assign jump     = last_ext - s_ext;
  assign jabs     = jump[B] ? unsigned'(-jump) : unsigned'(jump);
  assign jump_bad = CW'(jabs) >= CW'(coherency_limit);
  assign above    = s_ext > max_ext;
  assign below    = s_ext < min_ext;
  assign dmag     = above ? (s_ext - max_ext) : (min_ext - s_ext);
  assign prod     = PW'(tracking_gain) * PW'(dmag[B-1:0]);
  assign step     = prod[PW-1:CFG_W];

  assign err = ctrl.upd && (!valid || (seen_r && jump_bad));

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      min_r  <= '0;
      max_r  <= '0;
      last_r <= '0;
      seen_r <= 1'b0;
    end else if (ctrl.upd && valid) begin
      if (!seen_r) begin
        seen_r <= 1'b1;
        last_r <= sample;
        max_r  <= sample;
        min_r  <= sample;
      end else if (!jump_bad) begin
        last_r <= sample;
        if (above) begin
          max_r <= max_r + signed'(step);
        end
        if (below) begin
          min_r <= min_r - signed'(step);
        end
      end
    end
  end

  assign diff  = max_ext - min_ext;
  assign range = diff[B-1:0];
  assign bsum  = max_ext + min_ext;
  assign bias  = bsum[B:1];
  assign zero  = (range == '0);

  assign d_calc  = DW'(range) + (DW'(range) << 1);
  assign trial   = {rem_r, nlo_r[DIV_STEPS-1]};
  assign ge      = trial >= TW'(d_r);
  assign rem_nxt = ge ? DW'(trial - TW'(d_r)) : DW'(trial);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      d_r   <= d_calc;
      rem_r <= total >> SH;
      nlo_r <= {total[SH-1:0], GAIN_FRAC'(0)};
      q_r   <= '0;
      ovf_r <= (total >> SH) >= d_calc;
    end else if (ctrl.step) begin
      rem_r <= rem_nxt;
      nlo_r <= nlo_r << 1;
      q_r   <= {q_r[DIV_STEPS-2:0], ge};
    end
  end

  assign gain = zero ? '0 : (ovf_r ? '1 : GAIN_W'(q_r));

endmodule

`default_nettype wire

@@ rtl/mmc_merge.sv @@
// ----------------------------------------------------------------------------
// mmc_merge
// Combines lane findings: error count, range total and final status.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire mmc_pkg::merge_ctrl_t                             ctrl,
  input  wire logic [mmc_pkg::NLANES-1:0]                       lane_err,
  input  wire logic [mmc_pkg::NLANES-1:0]                       lane_zero,
  input  wire logic [mmc_pkg::NLANES-1:0][SAMPLE_BITS-1:0]      lane_range,
  input  wire logic [mmc_pkg::CFG_W-1:0]                        error_limit,
  output logic [SAMPLE_BITS+1:0]                                total,
  output logic [mmc_pkg::CNT_W-1:0]                             error_count,
  output mmc_pkg::status_t                                      status
);
  import mmc_pkg::*;

  localparam int TW = SAMPLE_BITS + 2;

  logic [TW-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]   cnt_sum;
  logic [1:0]       nerr;
  logic             fail;

  always_comb begin
    total_nxt = '0;
    for (int i = 0; i < NLANES; i++) begin
      total_nxt = total_nxt + TW'(lane_range[i]);
    end
  end

  assign nerr    = 2'($countones(lane_err));
  assign cnt_sum = (CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(nerr);
  assign cnt_nxt = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      cnt_r <= '0;
    end else if (ctrl.upd) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      total_r <= total_nxt;
    end
  end

  assign fail        = cnt_r > error_limit;
  assign total       = total_r;
  assign error_count = cnt_r;
  assign status      = fail ? STAT_FAIL : ((|lane_zero) ? STAT_ZERO : STAT_OK);

endmodule

`default_nettype wire

@@ rtl/magnetometer_minmax_calibration_top.sv @@
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_top
// Hard-iron bias and soft-iron gain from per-axis min/max tracking.
//
//   channel  dir  transfer when     payload
//   in_ch    in   valid && ready    timestamp, mag_x/y/z, last
//   out_ch   out  valid && ready    status, error_count, bias_x/y/z, gain_x/y/z
//   cfg_*    in   cfg_we            cfg_index, cfg_data
//
// A tick is captured while idle, then updates the three axis lanes in ST_UPD.
// A tick with last then passes through the range sum, divider load, 16 restoring
// division steps per lane (one quotient bit a cycle), and the result load.
// The result load waits while the output register holds an untaken result.
// Reset is synchronous and skips the sample, sum, divider and output data.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_minmax_calibration_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mmc_in_if.sink                            in_ch,
  mmc_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [mmc_pkg::CFG_W-1:0]    cfg_data
);
  import mmc_pkg::*;

  localparam int B    = SAMPLE_BITS;
  localparam int DC_W = $clog2(DIV_STEPS);
  localparam logic [DC_W-1:0] LAST_STEP = DC_W'(DIV_STEPS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_UPD  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] coh_r, gain_cfg_r, err_lim_r;

  logic [TS_W-1:0]           ts_r, prev_ts_r;
  logic [NLANES-1:0][B-1:0]  samp_r;
  logic                      last_r;
  logic [DC_W-1:0]           div_cnt_r;

  logic in_acc, fresh, emit_go;
  lane_ctrl_t  lctrl;
  merge_ctrl_t mctrl;

  logic [NLANES-1:0]              lane_err, lane_zero;
  logic [NLANES-1:0][B-1:0]       lane_range, lane_bias;
  logic [NLANES-1:0][GAIN_W-1:0]  lane_gain;
  logic [B+1:0]                   total;
  logic [CNT_W-1:0]               err_cnt;
  status_t                        status;

  logic                           out_valid_r;
  status_t                        out_status_r;
  logic [CNT_W-1:0]               out_cnt_r;
  logic [NLANES-1:0][B-1:0]       out_bias_r;
  logic [NLANES-1:0][GAIN_W-1:0]  out_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r      <= COHERENCY_RESET;
      gain_cfg_r <= GAIN_RESET;
      err_lim_r  <= ERR_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COHERENCY: coh_r      <= cfg_data;
        REG_GAIN:      gain_cfg_r <= cfg_data;
        REG_ERR_LIMIT: err_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fresh       = (ts_r != prev_ts_r);
  assign emit_go     = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ts_r      <= in_ch.timestamp;
      samp_r[0] <= in_ch.mag_x;
      samp_r[1] <= in_ch.mag_y;
      samp_r[2] <= in_ch.mag_z;
      last_r    <= in_ch.last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_r ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == LAST_STEP) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      prev_ts_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= (state_r == ST_DIV) ? div_cnt_r + 1'b1 : '0;
      if (emit_go) begin
        prev_ts_r <= '0;
      end else if (lctrl.upd) begin
        prev_ts_r <= ts_r;
      end
    end
  end

  assign lctrl.upd   = (state_r == ST_UPD) && fresh;
  assign lctrl.clear = emit_go;
  assign lctrl.load  = (state_r == ST_LOAD);
  assign lctrl.step  = (state_r == ST_DIV);

  assign mctrl.upd   = lctrl.upd;
  assign mctrl.sum   = (state_r == ST_SUM);
  assign mctrl.clear = emit_go;

  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    mmc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctrl            (lctrl),
      .sample          (signed'(samp_r[i])),
      .coherency_limit (coh_r),
      .tracking_gain   (gain_cfg_r),
      .total           (total),
      .err             (lane_err[i]),
      .zero            (lane_zero[i]),
      .range           (lane_range[i]),
      .bias            (lane_bias[i]),
      .gain            (lane_gain[i])
    );
  end

  mmc_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (mctrl),
    .lane_err    (lane_err),
    .lane_zero   (lane_zero),
    .lane_range  (lane_range),
    .error_limit (err_lim_r),
    .total       (total),
    .error_count (err_cnt),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status_r <= status;
      out_cnt_r    <= err_cnt;
      out_bias_r   <= (status == STAT_FAIL) ? '0 : lane_bias;
      out_gain_r   <= (status == STAT_FAIL) ? '0 : lane_gain;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.error_count = out_cnt_r;
  assign out_ch.bias_x      = signed'(out_bias_r[0]);
  assign out_ch.bias_y      = signed'(out_bias_r[1]);
  assign out_ch.bias_z      = signed'(out_bias_r[2]);
  assign out_ch.gain_x      = out_gain_r[0];
  assign out_ch.gain_y      = out_gain_r[1];
  assign out_ch.gain_z      = out_gain_r[2];

endmodule

`default_nettype wire

@@ rtl/mmc_checker.sv @@
// ----------------------------------------------------------------------------
// mmc_checker
// Port-level checks on the calibration block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    status,
  input wire logic [15:0]                   error_count,
  input wire logic [SAMPLE_BITS-1:0]        bias_x,
  input wire logic [SAMPLE_BITS-1:0]        bias_y,
  input wire logic [SAMPLE_BITS-1:0]        bias_z,
  input wire logic [15:0]                   gain_x,
  input wire logic [15:0]                   gain_y,
  input wire logic [15:0]                   gain_z
);
  import mmc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(error_count)
      && $stable(gain_x) && $stable(gain_y) && $stable(gain_z))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_FAIL) |-> (bias_x == '0) && (bias_y == '0)
      && (bias_z == '0) && (gain_x == '0) && (gain_y == '0) && (gain_z == '0))
    else $error("failed result carries nonzero calibration");

  a_ok_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_OK) |-> (gain_x != '0) && (gain_y != '0)
      && (gain_z != '0))
    else $error("successful result with zero gain");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in the update cycle");

endmodule

bind magnetometer_minmax_calibration_top mmc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .error_count (out_ch.error_count),
  .bias_x      (out_ch.bias_x),
  .bias_y      (out_ch.bias_y),
  .bias_z      (out_ch.bias_z),
  .gain_x      (out_ch.gain_x),
  .gain_y      (out_ch.gain_y),
  .gain_z      (out_ch.gain_z)
);

`default_nettype wire

@@ tb/tb_magnetometer_minmax_calibration_top.sv @@
// ----------------------------------------------------------------------------
// tb_magnetometer_minmax_calibration_top
// Self-checking bench for the magnetometer min/max calibration block. A local
// predictor tracks per-axis min/max, stale ticks, errors and the final
// bias/gain math. Each tick transfer updates it. Each result transfer is
// compared field by field with the oldest predicted result. Directed tests
// cover the sample bounds, the tracking and coherency edges, register
// extremes and the error limit edge. A back-pressure test and random
// sessions under several register settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_magnetometer_minmax_calibration_top;
  import mmc_pkg::*;

  localparam int VALID_BOUND  = (79 << 12) / 10;
  localparam int SETTLE       = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [31:0]      ts;
    logic [2:0][15:0] mag;
    logic             last;
  } tick_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      errs;
    logic [2:0][15:0] bias;
    logic [2:0][15:0] gain;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mmc_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  mmc_out_if #(.SAMPLE_BITS(16)) out_ch ();

  magnetometer_minmax_calibration_top #(.SAMPLE_BITS(16)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state and registers
  int unsigned coh_lim, trk_gain, err_lim;
  int          lo[3], hi[3], prev_s[3];
  bit          seen[3];
  logic [31:0] prev_ts;
  int unsigned rej_cnt;

  cal_result_t expected_results[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned transfers;
  int unsigned reg_writes;
  int unsigned sessions_run;
  int unsigned random_items;
  bit          gaps_on;
  int unsigned burst_left;
  bit          hold_request;
  logic [31:0] ts_cursor;

  function automatic void clear_session();
    for (int a = 0; a < 3; a++) begin
      lo[a] = 0;
      hi[a] = 0;
      prev_s[a] = 0;
      seen[a] = 1'b0;
    end
    prev_ts = '0;
    rej_cnt = 0;
  endfunction

  function automatic void count_reject();
    if (rej_cnt < 65535) rej_cnt++;
  endfunction

  function automatic int tracked_step(int delta);
    longint mag;
    longint st;
    mag = (delta < 0) ? -longint'(delta) : longint'(delta);
    st = (longint'(trk_gain) * mag) >> 16;
    return (delta < 0) ? -int'(st) : int'(st);
  endfunction

  function automatic void update_lane(int a, int s);
    int jump;
    if (s < -VALID_BOUND || s > VALID_BOUND) begin
      count_reject();
    end else if (!seen[a]) begin
      seen[a] = 1'b1;
      prev_s[a] = s;
      hi[a] = s;
      lo[a] = s;
    end else begin
      jump = prev_s[a] - s;
      if (jump < 0) jump = -jump;
      if (jump >= int'(coh_lim)) begin
        count_reject();
      end else begin
        prev_s[a] = s;
        if (s > hi[a]) hi[a] += tracked_step(s - hi[a]);
        if (s < lo[a]) lo[a] += tracked_step(s - lo[a]);
      end
    end
  endfunction

  function automatic bit predict_calibration(input tick_t t, output cal_result_t r);
    longint rng[3];
    longint total;
    longint g;
    r = '0;
    if (t.ts != prev_ts) begin
      prev_ts = t.ts;
      for (int a = 0; a < 3; a++) update_lane(a, int'($signed(t.mag[a])));
    end
    if (!t.last) return 1'b0;
    r.errs = rej_cnt[15:0];
    r.status = STAT_OK;
    if (rej_cnt > err_lim) begin
      r.status = STAT_FAIL;
    end else begin
      total = 0;
      for (int a = 0; a < 3; a++) begin
        rng[a] = (hi[a] > lo[a]) ? longint'(hi[a] - lo[a]) : 0;
        total += rng[a];
        r.bias[a] = 16'((hi[a] + lo[a]) >>> 1);
      end
      for (int a = 0; a < 3; a++) begin
        if (rng[a] == 0) begin
          r.status = STAT_ZERO;
        end else begin
          g = (total << 12) / (3 * rng[a]);
          r.gain[a] = (g > 65535) ? 16'hFFFF : 16'(g);
        end
      end
    end
    clear_session();
    return 1'b1;
  endfunction

  function automatic tick_t make_tick(logic [31:0] ts, int x, int y, int z, bit last);
    tick_t t;
    t.ts = ts;
    t.mag[0] = 16'(x);
    t.mag[1] = 16'(y);
    t.mag[2] = 16'(z);
    t.last = last;
    return t;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH result %0d %s: expected %0d, got %0d",
               results_checked, what, want, got);
  endtask

  task automatic send_tick(input tick_t t);
    cal_result_t r;
    in_ch.valid <= 1'b1;
    in_ch.timestamp <= t.ts;
    in_ch.mag_x <= t.mag[0];
    in_ch.mag_y <= t.mag[1];
    in_ch.mag_z <= t.mag[2];
    in_ch.last <= t.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    transfers++;
    if (predict_calibration(t, r)) expected_results.push_back(r);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_COHERENCY: coh_lim = v;
      REG_GAIN:      trk_gain = v;
      REG_ERR_LIMIT: err_lim = v;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [CFG_W-1:0] coh, logic [CFG_W-1:0] gain,
                                logic [CFG_W-1:0] lim);
    write_reg(REG_COHERENCY, coh);
    write_reg(REG_GAIN, gain);
    write_reg(REG_ERR_LIMIT, lim);
  endtask

  // sample bounds, stale ticks, stale last tick, zero range
  task automatic test_sample_bounds();
    gaps_on = 1'b1;
    send_tick(make_tick(0, 100, 100, 100, 0));
    send_tick(make_tick(1, VALID_BOUND, -VALID_BOUND, 0, 0));
    send_tick(make_tick(2, VALID_BOUND + 1, -VALID_BOUND - 1, -32768, 0));
    send_tick(make_tick(3, 32767, -32767, 0, 0));
    send_tick(make_tick(3, 0, 0, 0, 1));
    drain_results();
  endtask

  // tracking steps, coherency edge, gain saturation
  task automatic test_tracking();
    send_tick(make_tick(10, 0, 0, 0, 0));
    send_tick(make_tick(11, 10, 2047, -2047, 0));
    send_tick(make_tick(12, 10, 4095, -4095, 0));
    send_tick(make_tick(13, 10, 4094, -2047, 0));
    send_tick(make_tick(14, -1, 4094, -2047, 1));
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(make_tick(20, VALID_BOUND, -VALID_BOUND, 1, 0));
    send_tick(make_tick(21, -VALID_BOUND, VALID_BOUND, -1, 0));
    send_tick(make_tick(22, 0, 0, 0, 1));
    drain_results();
    write_all_regs(16'h0000, 16'h0000, 16'h0000);
    send_tick(make_tick(30, 100, 200, 300, 0));
    send_tick(make_tick(31, 100, 200, 300, 1));
    drain_results();
    write_reg(REG_ERR_LIMIT, 16'd3);
    send_tick(make_tick(40, 100, 200, 300, 0));
    send_tick(make_tick(41, 100, 200, 300, 1));
    drain_results();
    write_all_regs(COHERENCY_RESET, GAIN_RESET, ERR_LIMIT_RESET);
    send_tick(make_tick(50, -32768, 100, 100, 0));
    send_tick(make_tick(51, -32768, 300, 300, 1));
    drain_results();
  endtask

  // error count equal to the limit passes, one tick more fails
  task automatic test_error_limit();
    write_reg(REG_ERR_LIMIT, 16'd30);
    gaps_on = 1'b0;
    for (int i = 1; i <= 10; i++)
      send_tick(make_tick(i, -32768, -32768, -32768, i == 10));
    drain_results();
    for (int i = 1; i <= 11; i++)
      send_tick(make_tick(i, -32768, -32768, -32768, i == 11));
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_tick(make_tick(100 + 2 * i, 1000 * i, -500 * i, 7 * i, 0));
      send_tick(make_tick(101 + 2 * i, 1000 * i + 300, -500 * i - 300, 7 * i + 50, 1));
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic run_session(int n, int noise_pct);
    int lane[3];
    int jmax;
    tick_t t;
    jmax = (coh_lim == 0) ? 0 : ((coh_lim > 6000) ? 6000 : int'(coh_lim) - 1);
    for (int a = 0; a < 3; a++) lane[a] = int'($urandom_range(0, 40000)) - 20000;
    for (int k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(0, 14) != 0) ts_cursor += $urandom_range(1, 20000);
      t.ts = ts_cursor;
      for (int a = 0; a < 3; a++) begin
        lane[a] += int'($urandom_range(0, 2 * jmax)) - jmax;
        if (lane[a] > VALID_BOUND) lane[a] = VALID_BOUND;
        if (lane[a] < -VALID_BOUND) lane[a] = -VALID_BOUND;
        t.mag[a] = ($urandom_range(0, 99) < noise_pct) ? 16'($urandom) : 16'(lane[a]);
      end
      t.last = (k == n - 1);
      send_tick(t);
      random_items++;
    end
    sessions_run++;
  endtask

  task automatic test_random_sessions();
    tick_t t;
    logic [CFG_W-1:0] coh, gain, lim;
    int len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin coh = COHERENCY_RESET; gain = GAIN_RESET; lim = ERR_LIMIT_RESET; end
        1: begin coh = 16'hFFFF; gain = 16'hFFFF; lim = 16'hFFFF; end
        2: begin coh = 16'd1; gain = 16'h0000; lim = 16'h0000; end
        default: begin
          coh = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(300, 8000));
          gain = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
          lim = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30));
        end
      endcase
      write_all_regs(coh, gain, lim);
      ts_cursor = $urandom;
      while (random_items < (phase + 1) * (RANDOM_ITEMS / 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            t.ts = $urandom;
            for (int a = 0; a < 3; a++) t.mag[a] = 16'($urandom);
            t.last = ($urandom_range(0, 3) == 0);
            send_tick(t);
            random_items++;
          end
        end else begin
          case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = $urandom_range(40, 60);
            default: len = $urandom_range(2, 25);
          endcase
          run_session(len, $urandom_range(0, 12));
        end
      end
      drain_results();
    end
  endtask

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int beat;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 4);
        mode_left = $urandom_range(40, 160);
      end else begin
        mode_left--;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= $urandom_range(0, 1);
          3:       out_ch.ready <= (beat % 7) > 2;
          default: out_ch.ready <= (beat % 32) >= 20;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    cal_result_t want;
    logic [2:0][15:0] got_bias;
    logic [2:0][15:0] got_gain;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_results.pop_front();
        got_bias = {out_ch.bias_z, out_ch.bias_y, out_ch.bias_x};
        got_gain = {out_ch.gain_z, out_ch.gain_y, out_ch.gain_x};
        if (out_ch.status !== want.status)
          report_mismatch("status", want.status, out_ch.status);
        if (out_ch.error_count !== want.errs)
          report_mismatch("error_count", want.errs, out_ch.error_count);
        for (int a = 0; a < 3; a++) begin
          if (got_bias[a] !== want.bias[a])
            report_mismatch($sformatf("bias[%0d]", a), $signed(want.bias[a]),
                            $signed(got_bias[a]));
          if (got_gain[a] !== want.gain[a])
            report_mismatch($sformatf("gain[%0d]", a), want.gain[a], got_gain[a]);
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_magnetometer_minmax_calibration_top: done, errors");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    results_checked = 0;
    transfers = 0;
    reg_writes = 0;
    sessions_run = 0;
    random_items = 0;
    gaps_on = 1'b1;
    burst_left = 0;
    hold_request = 1'b0;
    ts_cursor = '0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.timestamp <= '0;
    in_ch.mag_x <= '0;
    in_ch.mag_y <= '0;
    in_ch.mag_z <= '0;
    in_ch.last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_COHERENCY;
    cfg_data <= '0;
    coh_lim = COHERENCY_RESET;
    trk_gain = GAIN_RESET;
    err_lim = ERR_LIMIT_RESET;
    clear_session();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_bounds();
    test_tracking();
    test_register_extremes();
    test_error_limit();
    test_backpressure();
    test_random_sessions();
    drain_results();

    $display("covered %0d tick transfers and %0d calibration results, %0d register writes",
             transfers, results_checked, reg_writes);
    $display("random part: %0d sessions, %0d ticks; error limit edge hit; %0d mismatches",
             sessions_run, random_items, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_magnetometer_minmax_calibration_top: done, clean");
    end else begin
      $display("tb_magnetometer_minmax_calibration_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/mmc_pkg.sv
rtl/mmc_if.sv
rtl/mmc_lane.sv
rtl/mmc_merge.sv
rtl/magnetometer_minmax_calibration_top.sv
rtl/mmc_checker.sv
tb/tb_magnetometer_minmax_calibration_top.sv
